### src/gyro_accel_attitude_filter_core_assert.svh
`ifndef GYRO_ACCEL_ATTITUDE_FILTER_CORE_ASSERT_SVH
`define GYRO_ACCEL_ATTITUDE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GAAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gaaf assertion failed");

// Next-cycle implication, checked outside reset.
`define GAAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gaaf assertion failed");

`endif

### src/gaaf_pkg.sv
`default_nettype none

package gaaf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 24;
   localparam int ANG_W  = 40;
   localparam int WIDE_W = 58;
   localparam int INC_W  = 26;
   localparam int RATE_W = 17;
   localparam int Z_W    = 26;
   localparam int CW     = 28;
   localparam int BLEND_BITS = 17;

   localparam logic [15:0] ALPHA_SKIP = 16'd65470;
   localparam logic [32:0] MAG_SQ_GATE = 33'd1509949;
   localparam logic signed [Z_W-1:0] HALF_TURN = 26'sd11796480;
   localparam logic [16:0] INC_DIVISOR = 17'd125000;
   localparam logic signed [41:0] INC_ROUND = 42'sd62500;
   localparam logic signed [WIDE_W-1:0] BLEND_ROUND = 58'sd32768;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [15:0]        step_time;
      logic [24:0]        angle_limit;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic signed [ANG_W-1:0] yaw_relative;
      logic signed [ANG_W-1:0] pitch_relative;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_SAMPLE      = 2'd0,
      MODE_REBASE      = 2'd1,
      MODE_LIMIT_YAW   = 2'd2,
      MODE_LIMIT_PITCH = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      CSR_YAW_AXIS       = 4'd0,
      CSR_PITCH_AXIS     = 4'd1,
      CSR_UP_AXIS        = 4'd2,
      CSR_FORWARD_AXIS   = 4'd3,
      CSR_YAW_NEGATE     = 4'd4,
      CSR_PITCH_NEGATE   = 4'd5,
      CSR_FORWARD_NEGATE = 4'd6,
      CSR_BLEND_ALPHA    = 4'd7
   } csr_index_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
      logic signed [Z_W-1:0] r;
      case (i)
         5'd0:  r = 26'sd2949120;
         5'd1:  r = 26'sd1740967;
         5'd2:  r = 26'sd919879;
         5'd3:  r = 26'sd466945;
         5'd4:  r = 26'sd234379;
         5'd5:  r = 26'sd117304;
         5'd6:  r = 26'sd58666;
         5'd7:  r = 26'sd29335;
         5'd8:  r = 26'sd14668;
         5'd9:  r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = 26'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-ANG_W:0] top;
      logic signed [ANG_W-1:0] r;
      top = v[WIDE_W-1:ANG_W-1];
      if ((&top) || !(|top)) begin
         r = v[ANG_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(ANG_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(ANG_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [15:0] pick3(input logic signed [15:0] a0,
                                                 input logic signed [15:0] a1,
                                                 input logic signed [15:0] a2,
                                                 input logic [1:0] axis);
      logic signed [15:0] r;
      case (axis)
         2'd0: r = a0;
         2'd1: r = a1;
         default: r = a2;
      endcase
      return r;
   endfunction

   function automatic logic signed [ANG_W-1:0] clamp_zero(input logic signed [ANG_W-1:0] angle,
                                                           input logic signed [ANG_W-1:0] zero,
                                                           input logic [24:0] limit);
      logic signed [WIDE_W-1:0] rel;
      logic signed [WIDE_W-1:0] lim;
      logic signed [ANG_W-1:0] r;
      rel = WIDE_W'(angle) - WIDE_W'(zero);
      lim = $signed(WIDE_W'(limit));
      r = zero;
      if (rel > lim) begin
         r = sat40(WIDE_W'(angle) - lim);
      end else if (rel < -lim) begin
         r = sat40(WIDE_W'(angle) + lim);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/gaaf_incr.sv
`default_nettype none

// Angle increment: a bit-serial multiply of rate by time step, then a
// restoring division by the microsecond scale, one quotient bit per cycle.
module gaaf_incr
   import gaaf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [RATE_W-1:0] rate,
   input  wire logic [15:0]              step_time,
   output logic                          done,
   output logic signed [INC_W-1:0]       inc
);

   typedef enum logic [2:0] {
      I_IDLE = 3'b001,
      I_MUL  = 3'b010,
      I_DIV  = 3'b100
   } incr_state_type;

   incr_state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic signed [32:0] mcand_ff, mcand_in;
   logic signed [32:0] acc_ff, acc_in;
   logic [15:0] mplier_ff, mplier_in;
   logic [40:0] num_ff, num_in;
   logic [17:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic signed [32:0] acc_next;
   logic signed [41:0] numer;
   logic [17:0] shifted;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      mcand_in = mcand_ff;
      acc_in = acc_ff;
      mplier_in = mplier_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      acc_next = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      numer = $signed({acc_next, 9'b0}) + INC_ROUND;
      shifted = {rem_ff[16:0], num_ff[40]};
      case (state_ff)
         I_IDLE: begin
            if (start) begin
               mcand_in = 33'(rate);
               mplier_in = step_time;
               acc_in = '0;
               cnt_in = '0;
               state_in = I_MUL;
            end
         end
         I_MUL: begin
            acc_in = acc_next;
            mcand_in = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               neg_in = numer[41];
               num_in = numer[41] ? ~numer[40:0] : numer[40:0];
               rem_in = '0;
               cnt_in = '0;
               state_in = I_DIV;
            end
         end
         I_DIV: begin
            if (shifted >= {1'b0, INC_DIVISOR}) begin
               rem_in = shifted - {1'b0, INC_DIVISOR};
               num_in = {num_ff[39:0], 1'b1};
            end else begin
               rem_in = shifted;
               num_in = {num_ff[39:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd40) begin
               done_in = 1'b1;
               state_in = I_IDLE;
            end
         end
         default: state_in = I_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= I_IDLE;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff <= acc_in;
      mplier_ff <= mplier_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign inc = neg_ff ? ~$signed({1'b0, num_ff[INC_W-2:0]})
                       : $signed({1'b0, num_ff[INC_W-2:0]});

endmodule

`default_nettype wire

### src/gyro_accel_attitude_filter_core.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_data (mode, gyro, accel, step, limit)
// rsp       out        rsp_valid/stall    rsp_data (status, relative yaw and pitch)
// csr       in         csr_valid/ready    csr_index, csr_data
//
// A sample item runs dispatch, a serial rate-times-step multiply, restoring division,
// increment collection, output and idle. With blend alpha below ALPHA_SKIP an accel
// check follows, and a correction adds CORDIC rotation steps, two serial blend
// multiplies and the final shift. Rebase and limit items, and zero-step samples, go
// from dispatch to output. Synchronous reset clears angles, offsets, state and output
// valid and loads CSR defaults. One item is in work at a time; a stalled result waits
// in the output register and holds the next item at its output step.
`default_nettype none

`include "gyro_accel_attitude_filter_core_assert.svh"

module gyro_accel_attitude_filter_core
   import gaaf_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int NSTEP = (CORDIC_STEPS < CORDIC_STEPS_MAX) ? CORDIC_STEPS
                                                             : CORDIC_STEPS_MAX;
   localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);
   localparam logic [4:0] MUL_LAST = 5'(BLEND_BITS - 1);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_DISPATCH = 10'b0000000010,
      S_INTEG    = 10'b0000000100,
      S_SQUARE   = 10'b0000001000,
      S_GATE     = 10'b0000010000,
      S_CORDIC   = 10'b0000100000,
      S_MUL_A    = 10'b0001000000,
      S_MUL_B    = 10'b0010000000,
      S_BLEND    = 10'b0100000000,
      S_OUT      = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   req_type item_ff, item_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic status_ff, status_in;

   logic [1:0] yaw_axis_ff, yaw_axis_in, pitch_axis_ff, pitch_axis_in;
   logic [1:0] up_axis_ff, up_axis_in, forward_axis_ff, forward_axis_in;
   logic yaw_negate_ff, yaw_negate_in, pitch_negate_ff, pitch_negate_in;
   logic forward_negate_ff, forward_negate_in;
   logic [15:0] blend_alpha_ff, blend_alpha_in;

   logic signed [ANG_W-1:0] yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic signed [ANG_W-1:0] yaw_zero_ff, yaw_zero_in, pitch_zero_ff, pitch_zero_in;

   logic signed [15:0] up_ff, up_in;
   logic signed [16:0] fwd_ff, fwd_in;
   logic [31:0] upsq_ff, upsq_in, fwsq_ff, fwsq_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [WIDE_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [BLEND_BITS-1:0] mplier_ff, mplier_in;

   logic incr_start;
   logic yaw_done, pitch_done;
   logic signed [INC_W-1:0] yaw_inc, pitch_inc;
   logic signed [RATE_W-1:0] yaw_rate, pitch_rate;
   logic signed [15:0] yaw_sel, pitch_sel, fwd_sel;
   logic signed [CW-1:0] cx0, cy0, dx, dy;

   always_comb begin
      yaw_sel = pick3(item_ff.gyro_x, item_ff.gyro_y, item_ff.gyro_z, yaw_axis_ff);
      pitch_sel = pick3(item_ff.gyro_x, item_ff.gyro_y, item_ff.gyro_z, pitch_axis_ff);
      fwd_sel = pick3(item_ff.accel_x, item_ff.accel_y, item_ff.accel_z, forward_axis_ff);
      yaw_rate = yaw_negate_ff ? -RATE_W'(yaw_sel) : RATE_W'(yaw_sel);
      pitch_rate = pitch_negate_ff ? -RATE_W'(pitch_sel) : RATE_W'(pitch_sel);
   end

   gaaf_incr u_yaw_incr (
      .clock     (clock),
      .reset     (reset),
      .start     (incr_start),
      .rate      (yaw_rate),
      .step_time (item_ff.step_time),
      .done      (yaw_done),
      .inc       (yaw_inc)
   );

   gaaf_incr u_pitch_incr (
      .clock     (clock),
      .reset     (reset),
      .start     (incr_start),
      .rate      (pitch_rate),
      .step_time (item_ff.step_time),
      .done      (pitch_done),
      .inc       (pitch_inc)
   );

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      status_in = status_ff;
      yaw_axis_in = yaw_axis_ff;
      pitch_axis_in = pitch_axis_ff;
      up_axis_in = up_axis_ff;
      forward_axis_in = forward_axis_ff;
      yaw_negate_in = yaw_negate_ff;
      pitch_negate_in = pitch_negate_ff;
      forward_negate_in = forward_negate_ff;
      blend_alpha_in = blend_alpha_ff;
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      yaw_zero_in = yaw_zero_ff;
      pitch_zero_in = pitch_zero_ff;
      up_in = up_ff;
      fwd_in = fwd_ff;
      upsq_in = upsq_ff;
      fwsq_in = fwsq_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      incr_start = 1'b0;
      cx0 = CW'(up_ff) <<< 8;
      cy0 = -(CW'(fwd_ff) <<< 8);
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_YAW_AXIS:       yaw_axis_in = csr_data[1:0];
            CSR_PITCH_AXIS:     pitch_axis_in = csr_data[1:0];
            CSR_UP_AXIS:        up_axis_in = csr_data[1:0];
            CSR_FORWARD_AXIS:   forward_axis_in = csr_data[1:0];
            CSR_YAW_NEGATE:     yaw_negate_in = csr_data[0];
            CSR_PITCH_NEGATE:   pitch_negate_in = csr_data[0];
            CSR_FORWARD_NEGATE: forward_negate_in = csr_data[0];
            CSR_BLEND_ALPHA:    blend_alpha_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = 1'b0;
            up_in = pick3(item_ff.accel_x, item_ff.accel_y, item_ff.accel_z, up_axis_ff);
            fwd_in = forward_negate_ff ? -17'(fwd_sel) : 17'(fwd_sel);
            state_in = S_OUT;
            case (mode_type'(item_ff.mode))
               MODE_SAMPLE: begin
                  if (item_ff.step_time == 16'd0) begin
                     status_in = 1'b1;
                  end else begin
                     incr_start = 1'b1;
                     state_in = S_INTEG;
                  end
               end
               MODE_REBASE: begin
                  yaw_zero_in = yaw_ff;
                  pitch_zero_in = pitch_ff;
               end
               MODE_LIMIT_YAW: begin
                  yaw_zero_in = clamp_zero(yaw_ff, yaw_zero_ff, item_ff.angle_limit);
               end
               default: begin
                  pitch_zero_in = clamp_zero(pitch_ff, pitch_zero_ff, item_ff.angle_limit);
               end
            endcase
         end
         S_INTEG: begin
            if (yaw_done && pitch_done) begin
               yaw_in = sat40(WIDE_W'(yaw_ff) + WIDE_W'(yaw_inc));
               pitch_in = sat40(WIDE_W'(pitch_ff) + WIDE_W'(pitch_inc));
               state_in = (blend_alpha_ff < ALPHA_SKIP) ? S_SQUARE : S_OUT;
            end
         end
         S_SQUARE: begin
            upsq_in = 32'(up_ff) * 32'(up_ff);
            fwsq_in = 32'(fwd_ff) * 32'(fwd_ff);
            state_in = S_GATE;
         end
         S_GATE: begin
            state_in = S_OUT;
            if ((33'(upsq_ff) + 33'(fwsq_ff)) > MAG_SQ_GATE) begin
               if (up_ff < 0) begin
                  z_in = (cy0 >= 0) ? HALF_TURN : -HALF_TURN;
                  x_in = -cx0;
                  y_in = -cy0;
               end else begin
                  z_in = '0;
                  x_in = cx0;
                  y_in = cy0;
               end
               cnt_in = '0;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (y_ff > 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_entry(cnt_ff);
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_entry(cnt_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) begin
               mcand_in = WIDE_W'(pitch_ff);
               mplier_in = {1'b0, blend_alpha_ff};
               acc_in = BLEND_ROUND;
               cnt_in = '0;
               state_in = S_MUL_A;
            end
         end
         S_MUL_A, S_MUL_B: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in = '0;
               if (state_ff == S_MUL_A) begin
                  mcand_in = WIDE_W'(z_ff);
                  mplier_in = 17'h10000 - {1'b0, blend_alpha_ff};
                  state_in = S_MUL_B;
               end else begin
                  state_in = S_BLEND;
               end
            end
         end
         S_BLEND: begin
            pitch_in = sat40(acc_ff >>> 16);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.yaw_relative = sat40(WIDE_W'(yaw_ff) - WIDE_W'(yaw_zero_ff));
               rsp_in.pitch_relative = sat40(WIDE_W'(pitch_ff) - WIDE_W'(pitch_zero_ff));
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         yaw_axis_ff <= 2'd2;
         pitch_axis_ff <= 2'd1;
         up_axis_ff <= 2'd2;
         forward_axis_ff <= 2'd0;
         yaw_negate_ff <= 1'b0;
         pitch_negate_ff <= 1'b0;
         forward_negate_ff <= 1'b0;
         blend_alpha_ff <= 16'd64225;
         yaw_ff <= '0;
         pitch_ff <= '0;
         yaw_zero_ff <= '0;
         pitch_zero_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         yaw_axis_ff <= yaw_axis_in;
         pitch_axis_ff <= pitch_axis_in;
         up_axis_ff <= up_axis_in;
         forward_axis_ff <= forward_axis_in;
         yaw_negate_ff <= yaw_negate_in;
         pitch_negate_ff <= pitch_negate_in;
         forward_negate_ff <= forward_negate_in;
         blend_alpha_ff <= blend_alpha_in;
         yaw_ff <= yaw_in;
         pitch_ff <= pitch_in;
         yaw_zero_ff <= yaw_zero_in;
         pitch_zero_ff <= pitch_zero_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff <= rsp_in;
      status_ff <= status_in;
      up_ff <= up_in;
      fwd_ff <= fwd_in;
      upsq_ff <= upsq_in;
      fwsq_ff <= fwsq_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   `GAAF_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && !req_stall,
                     state_ff == S_DISPATCH)
   `GAAF_ASSERT_NOW(a_cordic_count, clock, reset, state_ff == S_CORDIC, cnt_ff <= LAST_STEP)
   `GAAF_ASSERT_NOW(a_mul_count, clock, reset, state_ff == S_MUL_A || state_ff == S_MUL_B,
                    cnt_ff <= MUL_LAST)
   `GAAF_ASSERT_NEXT(a_out_delivers, clock, reset,
                     state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall),
                     rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire
